// ===== rtl/core/bmf_pkg.sv =====
// Package for the box mean filter core: sizes, register map and helper functions.
// No dependencies.
package bmf_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxRadiusDef = 3;
  localparam int unsigned MaxHeight    = 4096;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } reg_idx_t;

  // Reciprocal of the window count, scaled by 2^20: floor(s/n) = (s*m) >> 20 for s < 2^13 when r < 7.
  function automatic logic [20:0] recip(input logic [2:0] r);
    logic [20:0] m;
    begin
      unique case (r)
        3'd0: m = 21'd1048576;
        3'd1: m = 21'd116509;
        3'd2: m = 21'd41944;
        3'd3: m = 21'd21400;
        3'd4: m = 21'd12946;
        3'd5: m = 21'd8666;
        3'd6: m = 21'd6205;
        default: m = 21'd4661;
      endcase
      return m;
    end
  endfunction

endpackage

// ===== rtl/core/box_mean_filter_core.sv =====
// Box mean filter top level: line store memory, column window, sum and divide pipeline.
// Depends on bmf_pkg.
// Pipeline: a result is offered after its pixel transaction passes line store read, window
// shift, masked row sums, total and reciprocal multiply into the queue.
// Flow control: results held plus items in the pipe are capped at four, so the input
// stalls while that sum is four; any register write stalls the input while the
// output position is re-derived by a serial divide by the current width.
// Reset: counters and window clear, registers take their reset values; line store undefined.
module box_mean_filter_core #(
  parameter int unsigned MAX_WIDTH  = bmf_pkg::MaxWidthDef,
  parameter int unsigned MAX_RADIUS = bmf_pkg::MaxRadiusDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_mean_out,
  output logic        out_frame_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bmf_pkg::*;

  localparam int unsigned LINES = 2 * MAX_RADIUS;
  localparam int unsigned WSIDE = 2 * MAX_RADIUS + 1;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned LW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned DEPTH = LINES * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned SW    = 14;

  // ---------------- configuration
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  radius_r;
  logic        wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 13'd768;
      radius_r <= 2'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_r  <= pwdata[10:0];
        REG_HEIGHT: height_r <= pwdata[12:0];
        REG_RADIUS: radius_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {21'd0, width_r};
      REG_HEIGHT: prdata = {19'd0, height_r};
      REG_RADIUS: prdata = {30'd0, radius_r};
      default:    prdata = 32'd0;
    endcase
  end

  logic [12:0] w_eff;
  logic [12:0] h_eff;
  logic [RW-1:0] r_eff;
  always_comb begin
    w_eff = {2'b00, width_r};
    if (width_r == 11'd0) w_eff = 13'd1;
    else if (32'(width_r) > MAX_WIDTH) w_eff = 13'(MAX_WIDTH);
    h_eff = height_r;
    if (height_r == 13'd0) h_eff = 13'd1;
    else if (height_r > 13'(MaxHeight)) h_eff = 13'(MaxHeight);
    if (32'(radius_r) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(radius_r);
  end

  // ---------------- stage 0: counters and line store access
  logic [9:0]  in_col_r;
  logic [12:0] in_row_r;
  logic [LW-1:0] slot_r;    // in_row mod LINES
  logic [21:0] out_count_r;
  logic [12:0] ox_r;        // out_count split into column and row
  logic [21:0] oy_r;
  logic [23:0] total_r;

  // out_count / width, re-derived after a register write
  logic        div_busy_r;
  logic [4:0]  div_cnt_r;
  logic [21:0] div_q_r;
  logic [10:0] div_rem_r;
  logic [11:0] div_sh;
  logic        div_ge;
  assign div_sh = {div_rem_r, div_q_r[21]};
  assign div_ge = 13'(div_sh) >= w_eff;

  logic accept;
  logic [7:0] pix;
  logic [23:0] lag;
  logic [24:0] pos;         // in_row*w + in_col
  logic emit;
  logic last;
  logic [CW-1:0] col;
  assign accept = in_valid && in_ready;
  assign pix    = in_cmd ? 8'd0 : in_pixel_in;
  assign col    = CW'(in_col_r);
  assign lag    = 24'(r_eff) * 24'(w_eff) + 24'(r_eff);
  assign pos    = 25'(in_row_r) * 25'(w_eff) + 25'(in_col_r);
  assign emit   = {1'b0, pos} >= 26'(lag);
  assign last   = (25'(out_count_r) + 25'd1) >= 25'(total_r);

  always_ff @(posedge clk) total_r <= 24'(w_eff) * 24'(h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0; in_row_r <= '0; slot_r <= '0;
      out_count_r <= '0; ox_r <= '0; oy_r <= '0;
      div_busy_r <= 1'b0; div_cnt_r <= '0; div_q_r <= '0; div_rem_r <= '0;
    end else if (wr_en) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
      div_q_r    <= out_count_r;
      div_rem_r  <= '0;
    end else if (div_busy_r) begin
      div_q_r   <= {div_q_r[20:0], div_ge};
      div_rem_r <= div_ge ? 11'(13'(div_sh) - w_eff) : div_sh[10:0];
      div_cnt_r <= div_cnt_r + 5'd1;
      if (div_cnt_r == 5'd21) begin
        div_busy_r <= 1'b0;
        ox_r <= div_ge ? 13'(div_sh) - w_eff : 13'(div_sh);
        oy_r <= {div_q_r[20:0], div_ge};
      end
    end else if (accept) begin
      if (emit && last) begin
        in_col_r <= '0; in_row_r <= '0; slot_r <= '0;
        out_count_r <= '0; ox_r <= '0; oy_r <= '0;
      end else begin
        if (13'(in_col_r) + 13'd1 >= w_eff) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 13'd1;
          slot_r   <= (32'(slot_r) + 1 >= LINES) ? '0 : slot_r + LW'(1);
        end else begin
          in_col_r <= in_col_r + 10'd1;
        end
        if (emit) begin
          out_count_r <= out_count_r + 22'd1;
          if (ox_r + 13'd1 >= w_eff) begin
            ox_r <= '0; oy_r <= oy_r + 22'd1;
          end else begin
            ox_r <= ox_r + 13'd1;
          end
        end
      end
    end
  end

  // Line store: one word per column, holding that column's byte from each of the LINES rows.
  logic [8*LINES-1:0] mem [MAX_WIDTH];
  logic [8*LINES-1:0] rd_r;
  logic [8*LINES-1:0] fwd_word;
  logic [CW-1:0]      col_d_r;
  logic               wr_d_r;
  logic [8*LINES-1:0] wr_word_r;

  // Read-modify-write on the column word: read into rd_r, merge the new byte, register it, then write back.
  always_ff @(posedge clk) begin
    if (accept) rd_r <= mem[col];
    if (wr_d_r) mem[col_d_r] <= wr_word_r;
  end

  // stage 1 pipeline regs
  logic          s1_v_r, s1_emit_r, s1_last_r;
  logic [7:0]    s1_pix_r;
  logic [LW-1:0] s1_slot_r;
  logic [CW-1:0] s1_col_r;
  logic [12:0]   s1_x_r;
  logic [21:0]   s1_y_r;
  logic [8*LINES-1:0] merged;

  // forward words not yet in memory: the one being merged and the one being written
  logic fwd_hit_r, fwd1_hit_r;
  logic [8*LINES-1:0] wr_hold_r, fwd1_word_r;
  always_ff @(posedge clk) begin
    fwd_hit_r  <= accept && wr_d_r && (col_d_r == col);
    fwd1_hit_r <= accept && s1_v_r && (s1_col_r == col);
    if (accept) begin
      wr_hold_r   <= wr_word_r;
      fwd1_word_r <= merged;
    end
  end
  assign fwd_word = fwd1_hit_r ? fwd1_word_r : (fwd_hit_r ? wr_hold_r : rd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= accept;
    if (accept) begin
      s1_emit_r <= emit; s1_last_r <= last; s1_pix_r <= pix;
      s1_slot_r <= slot_r; s1_col_r <= col; s1_x_r <= ox_r; s1_y_r <= oy_r;
    end
  end

  logic [7:0] newcol [WSIDE];
  always_comb begin
    int unsigned bi;
    merged = fwd_word;
    for (int d = 1; d <= LINES; d++) begin
      bi = 32'(s1_slot_r) + LINES - d;
      if (bi >= LINES) bi = bi - LINES;
      newcol[WSIDE-1-d] = fwd_word[8*bi +: 8];
    end
    newcol[WSIDE-1] = s1_pix_r;
    merged[8*s1_slot_r +: 8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) wr_d_r <= 1'b0;
    else wr_d_r <= s1_v_r;
    if (s1_v_r) begin
      wr_word_r <= merged; col_d_r <= s1_col_r;
    end
  end

  // column window
  logic [7:0] win_r [WSIDE][WSIDE];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < WSIDE; j++)
        for (int k = 0; k < WSIDE; k++) win_r[j][k] <= 8'd0;
    end else if (s1_v_r) begin
      for (int j = 0; j < WSIDE; j++) begin
        for (int k = 0; k < WSIDE - 1; k++) win_r[j][k] <= win_r[j][k+1];
        win_r[j][WSIDE-1] <= newcol[j];
      end
    end
  end

  logic s2_v_r, s2_last_r;
  logic [12:0] s2_x_r;
  logic [21:0] s2_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else s2_v_r <= s1_v_r && s1_emit_r;
    if (s1_v_r) begin
      s2_last_r <= s1_last_r; s2_x_r <= s1_x_r; s2_y_r <= s1_y_r;
    end
  end

  // stage 2: masked row sums; the live window is the bottom-right (2r+1) square
  logic [SW-1:0] rsum [WSIDE];
  logic          rmask [WSIDE];
  always_comb begin
    for (int j = 0; j < WSIDE; j++) begin
      logic signed [24:0] ry;
      ry = $signed({3'b000, s2_y_r}) + 25'(j) + 25'(r_eff) - 25'(2 * MAX_RADIUS);
      rsum[j] = '0;
      rmask[j] = (32'(j) + 2 * 32'(r_eff) >= 2 * MAX_RADIUS) &&
                 (ry >= 0) && (ry < $signed({12'd0, h_eff}));
      for (int k = 0; k < WSIDE; k++) begin
        logic signed [14:0] cx;
        cx = $signed({2'b00, s2_x_r}) + 15'(k) + 15'(r_eff) - 15'(2 * MAX_RADIUS);
        if ((32'(k) + 2 * 32'(r_eff) >= 2 * MAX_RADIUS) &&
            (cx >= 0) && (cx < $signed({2'b00, w_eff})))
          rsum[j] = rsum[j] + SW'(win_r[j][k]);
      end
    end
  end

  logic [SW-1:0] rs_r [WSIDE];
  logic s3_v_r, s3_last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else s3_v_r <= s2_v_r;
    s3_last_r <= s2_last_r;
    for (int j = 0; j < WSIDE; j++) rs_r[j] <= rmask[j] ? rsum[j] : '0;
  end

  logic [SW-1:0] tot;
  always_comb begin
    tot = '0;
    for (int j = 0; j < WSIDE; j++) tot = tot + rs_r[j];
  end

  logic [SW-1:0] tot_r;
  logic s4_v_r, s4_last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else s4_v_r <= s3_v_r;
    tot_r <= tot; s4_last_r <= s3_last_r;
  end

  logic [33:0] prod;
  assign prod = 34'(tot_r) * 34'(recip(3'(r_eff)));

  // output skid: pipeline is at most four deep, so a FIFO of 4 plus credit stall
  logic [8:0] q_r [4];
  logic [2:0] cnt_r, inflight;
  logic [1:0] wp_r, rp_r;
  assign inflight = 3'(s1_v_r) + 3'(s2_v_r) + 3'(s3_v_r) + 3'(s4_v_r);
  assign in_ready = !div_busy_r && !wr_en && ((4'(cnt_r) + 4'(inflight)) < 4'd4);
  assign out_valid = cnt_r != 3'd0;
  assign out_mean_out = q_r[rp_r][7:0];
  assign out_frame_last = q_r[rp_r][8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= '0; rp_r <= '0;
    end else begin
      if (s4_v_r) wp_r <= wp_r + 2'd1;
      if (out_valid && out_ready) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(s4_v_r) - 3'(out_valid && out_ready);
    end
    if (s4_v_r) q_r[wp_r] <= {s4_last_r, prod[27:20]};
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (4'(cnt_r) + 4'(inflight)) <= 4'd4)
    else $error("credit exceeded");
  assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (prod[33:28] == 6'd0))
    else $error("mean out of range");

endmodule
